/* design/lcdv_pkg.sv */
// Package for the Luhn check digit validator: widths, pipeline split and
// digit arithmetic helpers.
// No dependencies; imported by luhn_check_digit_validate.
package lcdv_pkg;

  localparam int ID_WIDTH            = 40;
  localparam int DEF_PAYLOAD_DIGITS  = 9;
  localparam int MAX_PAYLOAD_DIGITS  = 18;
  localparam int DABBLE_STAGES       = 5;
  localparam int STEPS_PER_STAGE     = ID_WIDTH / DABBLE_STAGES;
  localparam int SUM_MAX_W           = $clog2(MAX_PAYLOAD_DIGITS * 9 + 1);
  localparam int MOD_STEPS           = SUM_MAX_W - 3;

  typedef logic [3:0] digit_t;

  function automatic digit_t luhn_weight(input digit_t d, input logic dbl);
    logic [4:0] t;
    t = {1'b0, d};
    if (dbl) begin
      t = {d, 1'b0};
      if (t > 5'd9) begin
        t = t - 5'd9;
      end
    end
    return t[3:0];
  endfunction

  function automatic digit_t mod10(input logic [SUM_MAX_W-1:0] v);
    logic [SUM_MAX_W-1:0] r;
    r = v;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= SUM_MAX_W'(10 << k)) begin
        r = r - SUM_MAX_W'(10 << k);
      end
    end
    return r[3:0];
  endfunction

endpackage

/* design/luhn_check_digit_validate.sv */
// Luhn mod 10 check digit validator, pipelined binary to decimal conversion.
// Depends on lcdv_pkg.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   in      | in_valid_i, in_stall_o, id_number_i  | into block
//   out     | out_valid_o, out_stall_i,            | out of block
//           | check_ok_o, computed_digit_o         |
//
// The block takes one word per cycle while in_stall_o is low.
// Five stages convert the number to decimal, eight bits per stage; one stage
// forms the weighted digit sum and one reduces it to the check digit.
// Each stage loads when it is empty or its successor loads, so bubbles close up.
// A stall holds each full stage with no empty stage after it; reset empties the pipeline.
module luhn_check_digit_validate #(
  parameter int PAYLOAD_DIGITS = lcdv_pkg::DEF_PAYLOAD_DIGITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcdv_pkg::ID_WIDTH-1:0] id_number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         check_ok_o,
  output logic [3:0]                   computed_digit_o
);
  import lcdv_pkg::*;

  localparam int NUM_DIGITS = PAYLOAD_DIGITS + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int SUM_W      = $clog2(PAYLOAD_DIGITS * 9 + 1);
  localparam int NSTAGES    = DABBLE_STAGES + 2;
  localparam int SUM_STAGE  = DABBLE_STAGES;
  localparam int LAST       = NSTAGES - 1;

  logic [NSTAGES-1:0] valid_q;
  logic [NSTAGES-1:0] load;

  logic [BCD_W-1:0]    bcd_q [DABBLE_STAGES];
  logic [ID_WIDTH-1:0] bin_q [DABBLE_STAGES-1];

  logic [SUM_W-1:0] sum_d, sum_q;
  digit_t           given_q;
  digit_t           digit_d, digit_q;
  logic             ok_d, ok_q;

  always_comb begin
    load[LAST] = !valid_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  assign in_stall_o = !load[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSTAGES; k++) begin
        if (load[k]) begin
          valid_q[k] <= (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  for (genvar s = 0; s < DABBLE_STAGES; s++) begin : g_dabble
    logic [BCD_W-1:0]    bcd_in, b;
    logic [ID_WIDTH-1:0] bin_in, x;

    if (s == 0) begin : g_first
      assign bcd_in = '0;
      assign bin_in = id_number_i;
    end else begin : g_next
      assign bcd_in = bcd_q[s-1];
      assign bin_in = bin_q[s-1];
    end

    always_comb begin
      b = bcd_in;
      x = bin_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
          if (b[4*k +: 4] >= 4'd5) begin
            b[4*k +: 4] = b[4*k +: 4] + 4'd3;
          end
        end
        b = {b[BCD_W-2:0], x[ID_WIDTH-1]};
        x = {x[ID_WIDTH-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (load[s]) begin
        bcd_q[s] <= b;
      end
    end

    if (s < DABBLE_STAGES - 1) begin : g_bin
      always_ff @(posedge clk_i) begin
        if (load[s]) begin
          bin_q[s] <= x;
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 1; k <= PAYLOAD_DIGITS; k++) begin
      sum_d = sum_d + SUM_W'(luhn_weight(bcd_q[DABBLE_STAGES-1][4*k +: 4], k[0]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[SUM_STAGE]) begin
      sum_q   <= sum_d;
      given_q <= bcd_q[DABBLE_STAGES-1][3:0];
    end
  end

  digit_t rem;
  assign rem     = mod10(SUM_MAX_W'(sum_q));
  assign digit_d = (rem == 4'd0) ? 4'd0 : 4'd10 - rem;
  assign ok_d    = (digit_d == given_q);

  always_ff @(posedge clk_i) begin
    if (load[LAST]) begin
      digit_q <= digit_d;
      ok_q    <= ok_d;
    end
  end

  assign out_valid_o      = valid_q[LAST];
  assign check_ok_o       = ok_q;
  assign computed_digit_o = digit_q;

  a_in_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[0])
    else $error("accepted word did not enter the first stage");

  a_full_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[SUM_STAGE] && !load[SUM_STAGE] |=> valid_q[SUM_STAGE] && $stable(sum_q))
    else $error("held sum stage lost or changed its word");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> computed_digit_o <= 4'd9)
    else $error("computed digit out of decimal range");

  a_given_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[SUM_STAGE] |-> given_q <= 4'd9)
    else $error("conversion produced an invalid decimal digit");

endmodule
